@@ rtl/shsp_pkg.sv @@
// Shared types and constants for the SIP header stream parser.
// Holds the result record, result kind codes, the known-name table and the
// result queue sizing. No dependencies.
`default_nettype none

package shsp_pkg;

  localparam logic [1:0] KIND_HEADER     = 2'd0;
  localparam logic [1:0] KIND_END_OK     = 2'd1;
  localparam logic [1:0] KIND_MALFORMED  = 2'd2;
  localparam logic [1:0] KIND_INCOMPLETE = 2'd3;

  localparam int NUM_NAMES    = 10;
  localparam int MAX_NAME_LEN = 14;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
    4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd7, 4'd7, 4'd12, 4'd12, 4'd14
  };

  // right-justified: character k of a name sits in byte (len-1-k)
  localparam logic [8*MAX_NAME_LEN-1:0] NAME_TXT [NUM_NAMES] = '{
    "to", "via", "from", "cseq", "route", "call-id", "contact",
    "content-type", "record-route", "content-length"
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  cls;
    logic [15:0] name_off;
    logic [15:0] name_len;
    logic [15:0] val_off;
    logic [15:0] val_len;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_out_t;

  // lower-case character idx of known name sel; idx must be below its length
  function automatic logic [7:0] name_char(input logic [3:0] sel, input logic [3:0] idx);
    logic [3:0] sh;
    sh = NAME_LEN[sel] - 4'd1 - idx;
    return NAME_TXT[sel][{sh, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/shsp_if.sv @@
// Valid/ready stream interfaces for the parser's input bytes and results.
// No dependencies.
`default_nettype none

interface shsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;
  modport source (output valid, data_byte, end_of_text, input ready);
  modport sink (input valid, data_byte, end_of_text, output ready);
endinterface

interface shsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  header_class;
  logic [15:0] name_offset;
  logic [15:0] name_length;
  logic [15:0] value_offset;
  logic [15:0] value_length;
  logic        last_of_run;
  modport source (output valid, result_kind, header_class, name_offset, name_length,
                  value_offset, value_length, last_of_run, input ready);
  modport sink (input valid, result_kind, header_class, name_offset, name_length,
                value_offset, value_length, last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/sip_header_stream_parser.sv @@
// Streaming SIP header parser top level: input register, parser core, result queue.
// A byte's results pass through the input register and the result queue before
// they are offered. Throughput: one byte per cycle while results drain; the queue
// admits a byte only with room for two results. Reset (rst_n low, synchronous)
// returns to the name state, position zero, and empties the input register and
// the result queue.
`default_nettype none

module sip_header_stream_parser #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  shsp_in_if.sink    in_chan,
  shsp_out_if.source out_chan
);

  logic       in_v_r;
  logic [7:0] byte_r;
  logic       eot_r;
  logic       advance;

  shsp_pkg::step_out_t           step;
  shsp_pkg::result_t             rd_data;
  logic [shsp_pkg::OUTQ_CW-1:0]  count;
  logic                          rd_valid;

  assign advance       = in_v_r && (count <= shsp_pkg::OUTQ_CW'(shsp_pkg::OUTQ_DEPTH - 2));
  assign in_chan.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.data_byte;
      eot_r  <= in_chan.end_of_text;
    end
  end

  shsp_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (advance),
    .data_byte   (byte_r),
    .end_of_text (eot_r),
    .step        (step)
  );

  shsp_out_fifo u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (advance),
    .wr       (step),
    .rd_valid (rd_valid),
    .rd_ready (out_chan.ready),
    .rd_data  (rd_data),
    .count    (count)
  );

  assign out_chan.valid        = rd_valid;
  assign out_chan.result_kind  = rd_data.kind;
  assign out_chan.header_class = rd_data.cls;
  assign out_chan.name_offset  = rd_data.name_off;
  assign out_chan.name_length  = rd_data.name_len;
  assign out_chan.value_offset = rd_data.val_off;
  assign out_chan.value_length = rd_data.val_len;
  assign out_chan.last_of_run  = rd_data.last;

endmodule

`default_nettype wire

@@ rtl/shsp_core.sv @@
// Parser state registers and the per-byte update: line tracking, folding,
// parallel name match and up to two results per byte. Uses shsp_pkg.
`default_nettype none

module shsp_core #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire logic [7:0]          data_byte,
  input  wire logic                end_of_text,
  output shsp_pkg::step_out_t      step
);

  localparam int PW = POSITION_WIDTH;

  localparam logic [2:0] ST_NAME   = 3'd0;
  localparam logic [2:0] ST_HCOLON = 3'd1;
  localparam logic [2:0] ST_SWS    = 3'd2;
  localparam logic [2:0] ST_VALUE  = 3'd3;
  localparam logic [2:0] ST_CR     = 3'd4;
  localparam logic [2:0] ST_LF     = 3'd5;
  localparam logic [2:0] ST_CRLF   = 3'd6;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [shsp_pkg::NUM_NAMES-1:0] ALL_NAMES = '1;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    sble_r, sble_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] tok_r, tok_nxt;
  logic [PW-1:0] nst_r, nst_nxt;
  logic [PW-1:0] nlen_r, nlen_nxt;
  logic [PW-1:0] lea_r, lea_nxt;
  logic [shsp_pkg::NUM_NAMES-1:0] mask_r, mask_nxt;
  logic          fin_r, fin_nxt;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v == {PW{1'b1}}) ? v : v + 1'b1;
  endfunction

  logic          is_crlf, is_wsp, is_colon;
  logic [7:0]    lc;
  logic          ale, redo, hdr, fin_emit;
  logic [1:0]    fin_kind;
  logic [PW-1:0] vend, vlen;
  logic [3:0]    cls;
  shsp_pkg::result_t hdr_res, fin_res;

  always_comb begin
    is_crlf  = (data_byte == CH_CR) || (data_byte == CH_LF);
    is_wsp   = (data_byte == CH_SP) || (data_byte == CH_TAB);
    is_colon = (data_byte == CH_COLON);
    lc       = ((data_byte >= 8'd65) && (data_byte <= 8'd90)) ? data_byte + 8'd32 : data_byte;

    state_nxt = state_r;
    sble_nxt  = sble_r;
    pos_nxt   = pos_r;
    tok_nxt   = tok_r;
    nst_nxt   = nst_r;
    nlen_nxt  = nlen_r;
    lea_nxt   = lea_r;
    mask_nxt  = mask_r;
    fin_nxt   = fin_r;
    ale       = 1'b0;
    redo      = 1'b0;
    hdr       = 1'b0;
    fin_emit  = 1'b0;
    fin_kind  = shsp_pkg::KIND_END_OK;
    vend      = lea_r;

    if (!fin_r) begin
      if (end_of_text) begin
        if (state_r == ST_VALUE) begin
          hdr  = 1'b1;
          vend = pos_r;
        end else if ((state_r == ST_CR || state_r == ST_LF || state_r == ST_CRLF) &&
                     sble_r == ST_VALUE) begin
          hdr = 1'b1;
        end else begin
          fin_kind = shsp_pkg::KIND_INCOMPLETE;
        end
        fin_emit = 1'b1;
        fin_nxt  = 1'b1;
      end else begin
        pos_nxt = sat_inc(pos_r);
        unique case (state_r)
          ST_NAME: begin
          end
          ST_HCOLON: begin
            if (is_colon) begin
              state_nxt = ST_SWS;
              tok_nxt   = sat_inc(pos_r);
            end else if (!is_wsp) begin
              fin_emit = 1'b1;
              fin_kind = shsp_pkg::KIND_MALFORMED;
              fin_nxt  = 1'b1;
            end
          end
          ST_SWS: begin
            if (is_crlf) begin
              sble_nxt  = ST_SWS;
              lea_nxt   = pos_r;
              state_nxt = (data_byte == CH_CR) ? ST_CR : ST_LF;
            end else if (!is_wsp) begin
              state_nxt = ST_VALUE;
              tok_nxt   = pos_r;
            end
          end
          ST_VALUE: begin
            if (is_crlf) begin
              sble_nxt  = ST_VALUE;
              lea_nxt   = pos_r;
              state_nxt = (data_byte == CH_CR) ? ST_CR : ST_LF;
            end
          end
          ST_CR: begin
            if (data_byte == CH_LF) state_nxt = ST_CRLF;
            else ale = 1'b1;
          end
          default: ale = 1'b1;
        endcase

        // first byte after a line end: fold, or close the line and reparse
        if (ale) begin
          if (sble_r == ST_SWS && is_wsp) begin
            state_nxt = ST_SWS;
          end else if (sble_r == ST_VALUE && is_wsp) begin
            state_nxt = ST_VALUE;
          end else begin
            hdr       = (sble_r == ST_VALUE);
            tok_nxt   = pos_r;
            nlen_nxt  = '0;
            mask_nxt  = ALL_NAMES;
            state_nxt = ST_NAME;
            sble_nxt  = ST_NAME;
            redo      = 1'b1;
          end
        end

        if (state_r == ST_NAME || redo) begin
          if (is_crlf) begin
            fin_emit = 1'b1;
            fin_kind = (pos_r == tok_nxt) ? shsp_pkg::KIND_END_OK : shsp_pkg::KIND_MALFORMED;
            fin_nxt  = 1'b1;
          end else if (is_colon || is_wsp) begin
            nst_nxt   = tok_nxt;
            state_nxt = is_colon ? ST_SWS : ST_HCOLON;
          end else begin
            for (int i = 0; i < shsp_pkg::NUM_NAMES; i++) begin
              if (!((nlen_nxt < PW'(shsp_pkg::NAME_LEN[i])) &&
                    (shsp_pkg::name_char(4'(i), nlen_nxt[3:0]) == lc)))
                mask_nxt[i] = 1'b0;
            end
            nlen_nxt = sat_inc(nlen_nxt);
          end
        end
      end
    end
  end

  always_comb begin
    cls = 4'd0;
    for (int i = shsp_pkg::NUM_NAMES - 1; i >= 0; i--) begin
      if (mask_r[i] && nlen_r == PW'(shsp_pkg::NAME_LEN[i])) cls = 4'(i + 1);
    end
    vlen = (vend >= tok_r) ? vend - tok_r : '0;

    hdr_res.kind     = shsp_pkg::KIND_HEADER;
    hdr_res.cls      = cls;
    hdr_res.name_off = 16'(nst_r);
    hdr_res.name_len = 16'(nlen_r);
    hdr_res.val_off  = 16'(tok_r);
    hdr_res.val_len  = 16'(vlen);
    hdr_res.last     = !fin_emit;

    fin_res          = '0;
    fin_res.kind     = fin_kind;
    fin_res.last     = 1'b1;

    step.r1 = fin_res;
    if (hdr) begin
      step.r0 = hdr_res;
      step.n  = fin_emit ? 2'd2 : 2'd1;
    end else begin
      step.r0 = fin_res;
      step.n  = fin_emit ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NAME;
      sble_r  <= ST_NAME;
      pos_r   <= '0;
      tok_r   <= '0;
      nst_r   <= '0;
      nlen_r  <= '0;
      lea_r   <= '0;
      mask_r  <= ALL_NAMES;
      fin_r   <= 1'b0;
    end else if (take) begin
      state_r <= state_nxt;
      sble_r  <= sble_nxt;
      pos_r   <= pos_nxt;
      tok_r   <= tok_nxt;
      nst_r   <= nst_nxt;
      nlen_r  <= nlen_nxt;
      lea_r   <= lea_nxt;
      mask_r  <= mask_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/shsp_out_fifo.sv @@
// Four-entry result queue that takes zero, one or two results per cycle
// and hands out one per transaction. Uses shsp_pkg.
`default_nettype none

module shsp_out_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire shsp_pkg::step_out_t     wr,
  output logic                         rd_valid,
  input  wire logic                    rd_ready,
  output shsp_pkg::result_t            rd_data,
  output logic [shsp_pkg::OUTQ_CW-1:0] count
);

  shsp_pkg::result_t mem [shsp_pkg::OUTQ_DEPTH];

  logic [shsp_pkg::OUTQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [shsp_pkg::OUTQ_CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]                   n_push;
  logic                         pop;

  always_comb begin
    n_push   = wr_en ? wr.n : 2'd0;
    rd_valid = (cnt_r != '0);
    pop      = rd_valid && rd_ready;
    rd_data  = mem[rp_r];
    wp_nxt   = wp_r + shsp_pkg::OUTQ_AW'(n_push);
    rp_nxt   = rp_r + shsp_pkg::OUTQ_AW'(pop);
    cnt_nxt  = cnt_r + shsp_pkg::OUTQ_CW'(n_push) - shsp_pkg::OUTQ_CW'(pop);
    count    = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem[wp_r] <= wr.r0;
    if (n_push == 2'd2) mem[wp_r + 1'b1] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/shsp_checker.sv @@
// Port-level checks for the SIP header stream parser, bound to the top level.
// Uses shsp_pkg result kind codes.
`default_nettype none

module shsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  result_kind,
  input wire logic [3:0]  header_class,
  input wire logic [15:0] name_offset,
  input wire logic [15:0] name_length,
  input wire logic [15:0] value_offset,
  input wire logic [15:0] value_length,
  input wire logic        last_of_run
);

  logic done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (out_valid && out_ready && result_kind != shsp_pkg::KIND_HEADER) begin
      done_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(value_length)
      && $stable(name_offset) && $stable(last_of_run))
    else $error("result changed while stalled");

  a_final_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind != shsp_pkg::KIND_HEADER |->
      header_class == 4'd0 && name_offset == 16'd0 && name_length == 16'd0 &&
      value_offset == 16'd0 && value_length == 16'd0 && last_of_run)
    else $error("final result with nonzero fields or not last");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == shsp_pkg::KIND_HEADER |->
      header_class <= 4'(shsp_pkg::NUM_NAMES))
    else $error("header class out of range");

  a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("second result of a run not ready");

  a_silent_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !out_valid)
    else $error("result after final result");

endmodule

bind sip_header_stream_parser shsp_checker u_shsp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .result_kind  (out_chan.result_kind),
  .header_class (out_chan.header_class),
  .name_offset  (out_chan.name_offset),
  .name_length  (out_chan.name_length),
  .value_offset (out_chan.value_offset),
  .value_length (out_chan.value_length),
  .last_of_run  (out_chan.last_of_run)
);

`default_nettype wire

@@ test/tb_sip_header_stream_parser.sv @@
// Testbench for sip_header_stream_parser: drives header text byte by byte and checks every
// result against a built-in parser model, with random bursts, stalls and backpressure.
// Depends on shsp_pkg (rtl/shsp_pkg.sv) and the stream interfaces (rtl/shsp_if.sv).
module tb_sip_header_stream_parser;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_SP = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_COLON = 8'd58;

  typedef enum logic [2:0] {
    PS_NAME, PS_HCOLON, PS_SWS, PS_VALUE, PS_CR, PS_LF, PS_CRLF
  } parse_state_e;

  typedef enum {EOL_CRLF, EOL_LF, EOL_CR} eol_e;

  string sip_names[10] = '{"to", "via", "from", "cseq", "route", "call-id", "contact",
                           "content-type", "record-route", "content-length"};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  shsp_in_if in_c ();
  shsp_out_if out_c ();

  sip_header_stream_parser #(.POSITION_WIDTH(16)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_c.sink),
    .out_chan(out_c.source)
  );

  always #5 clk = ~clk;

  // parser model state
  parse_state_e p_state, p_state_at_eol;
  logic [15:0] p_pos, p_tok_start, p_name_start, p_name_len, p_eol_at;
  logic [9:0] p_cand;
  bit p_done;
  shsp_pkg::result_t reports_due[$];

  int err_count = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_tick = 0;
  shsp_pkg::result_t head_report;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_wsp(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB;
  endfunction

  function automatic logic [3:0] header_class_of();
    for (int i = 0; i < 10; i++)
      if (p_cand[i] && p_name_len == sip_names[i].len()) return 4'(i + 1);
    return 4'd0;
  endfunction

  function automatic void add_report(input logic [1:0] kind, input logic [3:0] cls,
                                     input logic [15:0] no, input logic [15:0] nl,
                                     input logic [15:0] vo, input logic [15:0] vl);
    shsp_pkg::result_t r;
    r = '{kind: kind, cls: cls, name_off: no, name_len: nl, val_off: vo, val_len: vl,
          last: 1'b0};
    reports_due = {reports_due, r};
  endfunction

  function automatic void add_header(input logic [15:0] end_pos);
    logic [15:0] vl;
    vl = (end_pos >= p_tok_start) ? end_pos - p_tok_start : 16'd0;
    add_report(shsp_pkg::KIND_HEADER, header_class_of(), p_name_start, p_name_len,
               p_tok_start, vl);
  endfunction

  function automatic void end_section(input logic [1:0] kind);
    add_report(kind, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    p_done = 1;
  endfunction

  function automatic void new_line();
    p_tok_start = p_pos;
    p_name_len = 16'd0;
    p_cand = '1;
    p_state = PS_NAME;
    p_state_at_eol = PS_NAME;
  endfunction

  function automatic void match_name_char(input logic [7:0] b);
    logic [7:0] lc;
    lc = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
    for (int i = 0; i < 10; i++)
      if (!(p_name_len < sip_names[i].len() && sip_names[i][p_name_len] == lc))
        p_cand[i] = 1'b0;
    p_name_len = sat_inc16(p_name_len);
  endfunction

  function automatic void open_line_end(input logic [7:0] b);
    p_state_at_eol = p_state;
    p_eol_at = p_pos;
    p_state = (b == CH_CR) ? PS_CR : PS_LF;
  endfunction

  // first byte after a line end: fold or close the line; 1 = parse the byte again
  function automatic bit close_line(input logic [7:0] b);
    if (p_state_at_eol == PS_SWS && is_wsp(b)) begin
      p_state = PS_SWS;
      return 0;
    end
    if (p_state_at_eol == PS_VALUE && is_wsp(b)) begin
      p_state = PS_VALUE;
      return 0;
    end
    if (p_state_at_eol == PS_VALUE) add_header(p_eol_at);
    new_line();
    return 1;
  endfunction

  function automatic void parse_char(input logic [7:0] b);
    bit again;
    for (int pass = 0; pass < 2 && !p_done; pass++) begin
      again = 0;
      case (p_state)
        PS_NAME: begin
          if (b == CH_CR || b == CH_LF) begin
            end_section((p_pos == p_tok_start) ? shsp_pkg::KIND_END_OK
                                               : shsp_pkg::KIND_MALFORMED);
          end else if (b == CH_COLON || is_wsp(b)) begin
            p_name_start = p_tok_start;
            p_state = (b == CH_COLON) ? PS_SWS : PS_HCOLON;
          end else begin
            match_name_char(b);
          end
        end
        PS_HCOLON: begin
          if (b == CH_COLON) begin
            p_state = PS_SWS;
            p_tok_start = sat_inc16(p_pos);
          end else if (!is_wsp(b)) begin
            end_section(shsp_pkg::KIND_MALFORMED);
          end
        end
        PS_SWS: begin
          if (b == CH_CR || b == CH_LF) begin
            open_line_end(b);
          end else if (!is_wsp(b)) begin
            p_state = PS_VALUE;
            p_tok_start = p_pos;
          end
        end
        PS_VALUE: begin
          if (b == CH_CR || b == CH_LF) open_line_end(b);
        end
        PS_CR: begin
          if (b == CH_LF) p_state = PS_CRLF;
          else again = close_line(b);
        end
        default: again = close_line(b);
      endcase
      if (!again) break;
    end
  endfunction

  // predicts the results of one accepted transaction
  function automatic void parse_step(input logic [7:0] b, input logic eot);
    int n_before;
    n_before = reports_due.size();
    if (p_done) return;
    if (!eot) begin
      parse_char(b);
      p_pos = sat_inc16(p_pos);
    end else if (p_state == PS_VALUE) begin
      add_header(p_pos);
      end_section(shsp_pkg::KIND_END_OK);
    end else if (p_state inside {PS_CR, PS_LF, PS_CRLF} && p_state_at_eol == PS_VALUE) begin
      add_header(p_eol_at);
      end_section(shsp_pkg::KIND_END_OK);
    end else begin
      end_section(shsp_pkg::KIND_INCOMPLETE);
    end
    if (reports_due.size() > n_before) reports_due[$].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_wsp();
    return $urandom_range(0, 1) ? CH_SP : CH_TAB;
  endfunction

  function automatic logic [7:0] rand_name_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) begin
      b = 8'($urandom_range(97, 122));
      if ($urandom_range(0, 1)) b = b - 8'd32;
      return b;
    end
    do b = 8'($urandom_range(0, 255));
    while (b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_SP || b == CH_COLON);
    return b;
  endfunction

  function automatic logic [7:0] rand_value_byte(input bit first);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || (first && is_wsp(b)));
    return b;
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122 && $urandom_range(0, 1)) ? c - 8'd32 : c;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eot);
    if (burst_left == 0) begin
      in_c.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
    burst_left--;
    in_c.valid = 1'b1;
    in_c.data_byte = b;
    in_c.end_of_text = eot;
    do @(posedge clk); while (!in_c.ready);
    parse_step(b, eot);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_item(s[k], 1'b0);
  endtask

  task automatic send_eol(input eol_e e);
    if (e != EOL_LF) send_item(CH_CR, 1'b0);
    if (e != EOL_CR) send_item(CH_LF, 1'b0);
  endtask

  task automatic send_line(input string s, input eol_e e);
    send_text(s);
    send_eol(e);
  endtask

  task automatic wait_for_results();
    in_c.valid = 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_header();
    logic [7:0] nm[$];
    int i;
    if ($urandom_range(0, 3) == 0) begin
      i = $urandom_range(0, 9);
      for (int k = 0; k < sip_names[i].len(); k++)
        nm = {nm, mixed_case(sip_names[i][k])};
      case ($urandom_range(0, 3))
        1: nm[0] = rand_name_byte();
        2: nm = {nm, rand_name_byte()};
        3: void'(nm.pop_back());
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(0, 12)) nm = {nm, rand_name_byte()};
    end
    foreach (nm[k]) send_item(nm[k], 1'b0);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_item(rand_wsp(), 1'b0);
    send_item(CH_COLON, 1'b0);
    repeat ($urandom_range(0, 2)) send_item(rand_wsp(), 1'b0);
    if ($urandom_range(0, 7) != 0) begin
      send_item(rand_value_byte(1), 1'b0);
      repeat ($urandom_range(0, 23)) send_item(rand_value_byte(0), 1'b0);
    end
    send_eol(eol_e'($urandom_range(0, 2)));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) send_item(rand_wsp(), 1'b0);
      repeat ($urandom_range(0, 8)) send_item(rand_value_byte(0), 1'b0);
      send_eol(eol_e'($urandom_range(0, 2)));
    end
  endtask

  task automatic test_known_names();
    for (int i = 0; i < 10; i++) begin
      for (int k = 0; k < sip_names[i].len(); k++) send_item(mixed_case(sip_names[i][k]), 1'b0);
      send_line(": v1", EOL_CRLF);
    end
    send_line("Xoute: r", EOL_CRLF);
    send_line("rout: r", EOL_CRLF);
    send_line("Routes: r", EOL_CRLF);
    send_line("CONTENT-LENGTH:0", EOL_LF);
  endtask

  task automatic test_line_forms();
    send_line("Via :  SIP/2.0/UDP h", EOL_CRLF);
    send_line("To\t:\tv", EOL_LF);
    send_line("Contact: <sip:a>", EOL_CRLF);
    send_line(" ;q=1", EOL_CRLF);
    send_line("\t;x", EOL_LF);
    send_line("Subject:", EOL_CRLF);
    send_line("Subject:  ", EOL_CR);
    send_line("  late", EOL_CRLF);
    send_line("From: b", EOL_CR);
    send_line(": anon", EOL_CRLF);
    send_item(8'hFF, 1'b0);
    send_text(":");
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    send_eol(EOL_LF);
  endtask

  task automatic test_random_headers();
    int stop_at;
    stop_at = bytes_sent + 500;
    while (bytes_sent < stop_at && !p_done) send_random_header();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    repeat (16) send_line("a:b", EOL_LF);
    wait_for_results();
  endtask

  task automatic test_termination();
    case ($urandom_range(0, 4))
      0: send_eol(eol_e'($urandom_range(0, 2)));
      1: begin
        send_text("Max-Forwards: 70");
        if ($urandom_range(0, 1)) send_eol(eol_e'($urandom_range(0, 2)));
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        send_text($urandom_range(0, 1) ? "Partial" : "Partial:  ");
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      3: begin
        send_text("Bad");
        if ($urandom_range(0, 1)) send_text(" Name");
        else send_eol(eol_e'($urandom_range(0, 2)));
      end
      default: begin
        for (int k = 0; k < 60 && !p_done; k++) send_item(8'($urandom_range(0, 255)), 1'b0);
        if (!p_done) send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  task automatic test_after_finish();
    repeat (12) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 100) $error("%s: expected %0d, got %0d", fname, want, got);
    end
  endtask

  // receiver: random stall patterns, plus one long hold-off on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      out_c.ready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      out_c.ready = 1'b0;
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 128);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_c.ready = 1'b1;
        1: out_c.ready = $urandom_range(0, 3) != 0;
        2: out_c.ready = $urandom_range(0, 3) == 0;
        default: out_c.ready = (rx_tick % 3) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_c.valid && out_c.ready) begin
      if (reports_due.size() == 0) begin
        err_count++;
        if (err_count <= 100) $error("unpredicted result, result_kind %0d", out_c.result_kind);
      end else begin
        head_report = reports_due.pop_front();
        check_field("result_kind", head_report.kind, out_c.result_kind);
        check_field("header_class", head_report.cls, out_c.header_class);
        check_field("name_offset", head_report.name_off, out_c.name_offset);
        check_field("name_length", head_report.name_len, out_c.name_length);
        check_field("value_offset", head_report.val_off, out_c.value_offset);
        check_field("value_length", head_report.val_len, out_c.value_length);
        check_field("last_of_run", head_report.last, out_c.last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_c.valid = 1'b0;
    in_c.data_byte = 8'd0;
    in_c.end_of_text = 1'b0;
    out_c.ready = 1'b0;
    p_pos = 16'd0;
    p_name_start = 16'd0;
    p_eol_at = 16'd0;
    p_done = 0;
    new_line();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_known_names();
    test_line_forms();
    test_random_headers();
    test_backpressure();
    test_termination();
    test_after_finish();

    wait_for_results();
    repeat (20) @(posedge clk);
    if (err_count == 0 && reports_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/shsp_pkg.sv
rtl/shsp_if.sv
rtl/shsp_core.sv
rtl/shsp_out_fifo.sv
rtl/sip_header_stream_parser.sv
rtl/shsp_checker.sv
test/tb_sip_header_stream_parser.sv
